FILE: rtl/core/gjl_pkg.sv
package gjl_pkg;

  // Datapath widths
  localparam int unsigned JdnW  = 23;
  localparam int unsigned CorrW = 20;

  // Correlation constant loaded at reset
  localparam logic [CorrW-1:0] CorrReset = 20'd584285;

  // Register stages from the front output to the date and long-count results
  localparam int unsigned PipeDepth = 7;

  // Input date forms
  typedef enum logic [1:0] {
    KindGreg = 2'd0,
    KindJdn  = 2'd1,
    KindLong = 2'd2
  } kind_e;

  // Day number word from the front end
  typedef struct packed {
    logic            vld;
    logic            ok;
    logic [JdnW-1:0] z;
  } jdn_word_t;

  // Gregorian result word
  typedef struct packed {
    logic            vld;
    logic            ok;
    logic [JdnW-1:0] z;
    logic [4:0]      day;
    logic [3:0]      month;
    logic [13:0]     year;
  } greg_word_t;

  // Long count digits
  typedef struct packed {
    logic [5:0] baktun;
    logic [4:0] katun;
    logic [4:0] tun;
    logic [4:0] uinal;
    logic [4:0] kin;
  } lc_dig_t;

  typedef struct packed {
    logic    vld;
    lc_dig_t dig;
  } lc_word_t;

  // Days before the start of a shifted month: floor(30.6001 * idx)
  function automatic logic [8:0] month_base(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/gjl_front.sv
module gjl_front import gjl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_vld_i,
  input  logic [1:0]       kind_i,
  input  logic [4:0]       in_day_i,
  input  logic [3:0]       in_month_i,
  input  logic [13:0]      in_year_i,
  input  logic [JdnW-1:0]  in_day_number_i,
  input  logic [4:0]       in_baktun_i,
  input  logic [4:0]       in_katun_i,
  input  logic [4:0]       in_tun_i,
  input  logic [4:0]       in_uinal_i,
  input  logic [4:0]       in_kin_i,
  input  logic [CorrW-1:0] corr_i,
  output jdn_word_t        jdn_o,
  output logic             active_o
);

  // Month length with the leap day
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] r;
    case (mon)
      4'd2:    r = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // ---------------- stage 1: products and digit checks ----------------
  logic               early;
  logic signed [14:0] yp;
  logic signed [25:0] yp_w;
  logic [26:0]        cent_prod;
  logic [26:0]        yc_prod;
  logic [3:0]         jm;

  logic               s1_vld_q;
  logic [1:0]         kind_q;
  logic [4:0]         day_q;
  logic [3:0]         month_q;
  logic [13:0]        year_q;
  logic [7:0]         yc_d, yc_q;
  logic signed [25:0] p_d, p_q;
  logic signed [8:0]  cent_d, cent_q;
  logic [8:0]         mo_d, mo_q;
  logic [JdnW-1:0]    lcnum_d, lcnum_q;
  logic               lcok_d, lcok_q;
  logic [JdnW-1:0]    dn_q;

  // January and February count as months 13 and 14 of the year before
  assign early     = (in_month_i == 4'd1) || (in_month_i == 4'd2);
  assign yp        = signed'({1'b0, in_year_i}) - (early ? 15'sd1 : 15'sd0);
  assign yp_w      = 26'(yp);
  assign p_d       = yp_w * 26'sd1461;
  // Divide by 100 with a reciprocal, exact below 43690
  assign cent_prod = 27'(yp[13:0]) * 27'd5243;
  assign cent_d    = yp[14] ? -9'sd1 : signed'({1'b0, cent_prod[26:19]});
  assign yc_prod   = 27'(in_year_i) * 27'd5243;
  assign yc_d      = yc_prod[26:19];
  assign jm        = early ? in_month_i + 4'd13 : in_month_i + 4'd1;
  assign mo_d      = month_base(jm);

  // Long count day offset and digit ranges
  assign lcnum_d = 23'(in_baktun_i) * 23'd144000 + 23'(in_katun_i) * 23'd7200
                 + 23'(in_tun_i) * 23'd360 + 23'(in_uinal_i) * 23'd20 + 23'(in_kin_i);
  assign lcok_d  = (in_baktun_i inside {[5'd1:5'd19]}) && (in_katun_i inside {[5'd1:5'd19]})
                && (in_tun_i inside {[5'd1:5'd19]}) && (in_uinal_i inside {[5'd1:5'd17]})
                && (in_kin_i inside {[5'd1:5'd19]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_i;
    day_q   <= in_day_i;
    month_q <= in_month_i;
    year_q  <= in_year_i;
    yc_q    <= yc_d;
    p_q     <= p_d;
    cent_q  <= cent_d;
    mo_q    <= mo_d;
    lcnum_q <= lcnum_d;
    lcok_q  <= lcok_d;
    dn_q    <= in_day_number_i;
  end

  // ---------------- stage 2: checks and day number ----------------
  logic               leap;
  logic [4:0]         mlen;
  logic               greg_ok;
  logic signed [26:0] zg;
  logic [JdnW:0]      zl;
  logic               ok_d, ok_q;
  logic [JdnW-1:0]    z_d, z_q;
  logic               s2_vld_q;

  assign leap    = (year_q[1:0] == 2'b00)
                && ((14'(14'(yc_q) * 14'd100) != year_q) || (yc_q[1:0] == 2'b00));
  assign mlen    = month_len(month_q, leap);
  assign greg_ok = (month_q inside {[4'd1:4'd12]}) && (day_q != 5'd0) && (day_q <= mlen);
  assign zg      = 27'(p_q >>> 2) + 27'(signed'({1'b0, mo_q})) + 27'(signed'({1'b0, day_q}))
                 + 27'sd1720997 - 27'(cent_q) + 27'(cent_q >>> 2);
  assign zl      = 24'(lcnum_q) + 24'(corr_i);

  // Select the day number of the input form
  always_comb begin
    case (kind_q)
      KindGreg: begin
        ok_d = greg_ok;
        z_d  = zg[JdnW-1:0];
      end
      KindJdn: begin
        ok_d = (dn_q >= 23'(corr_i));
        z_d  = dn_q;
      end
      KindLong: begin
        ok_d = lcok_q;
        z_d  = zl[JdnW-1:0];
      end
      default: begin
        ok_d = 1'b0;
        z_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q <= ok_d;
    z_q  <= z_d;
  end

  assign jdn_o    = '{vld: s2_vld_q, ok: ok_q, z: z_q};
  assign active_o = s1_vld_q | s2_vld_q;

endmodule

FILE: rtl/core/gjl_greg.sv
module gjl_greg import gjl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  jdn_word_t  jdn_i,
  output greg_word_t greg_o,
  output logic       active_o
);

  localparam int unsigned StgN = PipeDepth;

  // Valid, check flag and day number travel with every stage
  logic [StgN-1:0] vld_q;
  logic [StgN-1:0] ok_q;
  logic [JdnW-1:0] z_q [StgN];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[StgN-2:0], jdn_i.vld};
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q   <= {ok_q[StgN-2:0], jdn_i.ok};
    z_q[0] <= jdn_i.z;
    for (int i = 1; i < StgN; i++) begin
      z_q[i] <= z_q[i-1];
    end
  end

  // Stage 0: estimate the century count from 4z + offset over 146097
  logic [25:0] n1_in;
  logic [34:0] p1;
  logic [7:0]  q1e_d, q1e_q;

  assign n1_in = 26'({jdn_i.z, 2'b00}) + 26'd128179;
  assign p1    = 35'(n1_in) * 35'd459;
  assign q1e_d = p1[33:26];

  // Stage 1: correct the estimate by one
  logic [25:0] n1_s1;
  logic [25:0] r1;
  logic [7:0]  q1_d, q1_q;

  assign n1_s1 = 26'({z_q[0], 2'b00}) + 26'd128179;
  assign r1    = n1_s1 - 26'(26'(q1e_q) * 26'd146097);
  assign q1_d  = q1e_q + 8'(r1 >= 26'd146097);

  // Stage 2: shifted day count and the numerator of the year divide
  logic [7:0]  qa;
  logic [23:0] s;
  logic [23:0] b2_d, b2_q;
  logic [29:0] n2_d, n2_q;

  assign qa   = q1_q - (q1_q >> 2);
  assign s    = 24'(z_q[1]) + 24'(qa);
  assign b2_d = s + 24'd1486;
  assign n2_d = 30'(s) * 30'd100 + 30'd136390;

  // Stage 3: estimate the year count over 36525
  logic [44:0] p2;
  logic [14:0] ce_d, ce_q;
  logic [23:0] b3_q;
  logic [29:0] n2b_q;

  assign p2   = 45'(n2_q) * 45'd29397;
  assign ce_d = p2[44:30];

  // Stage 4: correct the year count
  logic [29:0] r2;
  logic [14:0] c4_d, c4_q;
  logic [23:0] b4_q;

  assign r2   = n2b_q - 30'(30'(ce_q) * 30'd36525);
  assign c4_d = ce_q + 15'(r2 >= 30'd36525);

  // Stage 5: day within the shifted year
  logic [25:0] ddp;
  logic [23:0] dd;
  logic [8:0]  x_d, x_q;
  logic [14:0] c5_q;

  assign ddp = 26'(c4_q) * 26'd1461;
  assign dd  = ddp[25:2];
  assign x_d = 9'(b4_q - dd);

  // Stage 6: month by threshold count, then day and year
  logic [3:0]  e;
  logic [4:0]  day_d, day_q;
  logic [3:0]  month_d, month_q;
  logic [13:0] year_d, year_q;

  always_comb begin
    e = 4'd4;
    for (int k = 5; k < 16; k++) begin
      if (x_q > month_base(4'(k))) begin
        e = e + 4'd1;
      end
    end
    day_d   = 5'(x_q - month_base(e));
    month_d = (e > 4'd13) ? e - 4'd13 : e - 4'd1;
    year_d  = (e > 4'd13) ? 14'(c5_q - 15'd4715) : 14'(c5_q - 15'd4716);
  end

  always_ff @(posedge clk_i) begin
    q1e_q   <= q1e_d;
    q1_q    <= q1_d;
    b2_q    <= b2_d;
    n2_q    <= n2_d;
    ce_q    <= ce_d;
    b3_q    <= b2_q;
    n2b_q   <= n2_q;
    c4_q    <= c4_d;
    b4_q    <= b3_q;
    x_q     <= x_d;
    c5_q    <= c4_q;
    day_q   <= day_d;
    month_q <= month_d;
    year_q  <= year_d;
  end

  assign greg_o = '{vld: vld_q[StgN-1], ok: ok_q[StgN-1], z: z_q[StgN-1],
                    day: day_q, month: month_q, year: year_q};
  assign active_o = |vld_q;

endmodule

FILE: rtl/core/gjl_lcount.sv
module gjl_lcount import gjl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  jdn_word_t        jdn_i,
  input  logic [CorrW-1:0] corr_i,
  output lc_word_t         lc_o
);

  // Stages after the digit stage that keep step with the Gregorian chain
  localparam int unsigned AlignN = PipeDepth - 4;

  logic [2:0]      vld_q;
  logic [AlignN:0] dvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      dvld_q <= '0;
    end else begin
      vld_q  <= {vld_q[1:0], jdn_i.vld};
      dvld_q <= {dvld_q[AlignN-1:0], vld_q[2]};
    end
  end

  // Stage 0: days since long count zero
  logic [JdnW-1:0] lc_d, lc_q, lc1_q;

  assign lc_d = jdn_i.z - 23'(corr_i);

  // Stage 1: quotient estimates over 20, 360, 7200 and 144000 with the
  // power-of-two part taken off first
  logic [20:0] u1;
  logic [19:0] v1;
  logic [17:0] w1;
  logic [15:0] t1;
  logic [39:0] pu;
  logic [34:0] pv;
  logic [28:0] pw;
  logic [21:0] pt;
  logic [18:0] e20_d, e20_q;
  logic [14:0] e360_d, e360_q;
  logic [10:0] e7k_d, e7k_q;
  logic [5:0]  e144_d, e144_q;

  assign u1     = lc_q[22:2];
  assign v1     = lc_q[22:3];
  assign w1     = lc_q[22:5];
  assign t1     = lc_q[22:7];
  assign pu     = 40'(u1) * 40'd419430;
  assign pv     = 35'(v1) * 35'd23301;
  assign pw     = 29'(w1) * 29'd1165;
  assign pt     = 22'(t1) * 22'd58;
  assign e20_d  = pu[39:21];
  assign e360_d = pv[34:20];
  assign e7k_d  = pw[28:18];
  assign e144_d = pt[21:16];

  // Stage 2: correct each estimate by one
  logic [20:0] u2, r20;
  logic [19:0] v2, r360;
  logic [17:0] w2, r7k;
  logic [15:0] t2, r144;
  logic [18:0] q20_d, q20_q;
  logic [14:0] q360_d, q360_q;
  logic [10:0] q7k_d, q7k_q;
  logic [5:0]  q144_d, q144_q;
  logic [4:0]  lc5_q;

  assign u2     = lc1_q[22:2];
  assign v2     = lc1_q[22:3];
  assign w2     = lc1_q[22:5];
  assign t2     = lc1_q[22:7];
  assign r20    = u2 - 21'(21'(e20_q) * 21'd5);
  assign r360   = v2 - 20'(20'(e360_q) * 20'd45);
  assign r7k    = w2 - 18'(18'(e7k_q) * 18'd225);
  assign r144   = t2 - 16'(16'(e144_q) * 16'd1125);
  assign q20_d  = e20_q + 19'(r20 >= 21'd5);
  assign q360_d = e360_q + 15'(r360 >= 20'd45);
  assign q7k_d  = e7k_q + 11'(r7k >= 18'd225);
  assign q144_d = e144_q + 6'(r144 >= 16'd1125);

  // Stage 3: each digit is its quotient less the next coarser one scaled
  lc_dig_t dig_d;
  lc_dig_t dig_q [AlignN+1];

  assign dig_d.baktun = q144_q;
  assign dig_d.katun  = 5'(q7k_q - 11'(11'(q144_q) * 11'd20));
  assign dig_d.tun    = 5'(q360_q - 15'(15'(q7k_q) * 15'd20));
  assign dig_d.uinal  = 5'(q20_q - 19'(19'(q360_q) * 19'd18));
  assign dig_d.kin    = lc5_q - 5'(q20_q * 19'd20);

  always_ff @(posedge clk_i) begin
    lc_q     <= lc_d;
    lc1_q    <= lc_q;
    e20_q    <= e20_d;
    e360_q   <= e360_d;
    e7k_q    <= e7k_d;
    e144_q   <= e144_d;
    q20_q    <= q20_d;
    q360_q   <= q360_d;
    q7k_q    <= q7k_d;
    q144_q   <= q144_d;
    lc5_q    <= lc1_q[4:0];
    dig_q[0] <= dig_d;
    for (int i = 1; i <= AlignN; i++) begin
      dig_q[i] <= dig_q[i-1];
    end
  end

  assign lc_o = '{vld: dvld_q[AlignN], dig: dig_q[AlignN]};

endmodule

FILE: rtl/core/gregorian_jdn_longcount_converter.sv
// done_o strobes a result word once the date word has passed through the path given below.
// Throughput: one date word per cycle while busy is low; busy is high only while a config write is offered.
// The path is the 2-stage front decode, the 7-stage day-number-to-date chain and the output register.
// A config write completes only when no date word is in flight.
// Reset clears every stage valid bit and loads the correlation register with 584285.
module gregorian_jdn_longcount_converter import gjl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       kind_i,
  input  logic [4:0]       in_day_i,
  input  logic [3:0]       in_month_i,
  input  logic [13:0]      in_year_i,
  input  logic [22:0]      in_day_number_i,
  input  logic [4:0]       in_baktun_i,
  input  logic [4:0]       in_katun_i,
  input  logic [4:0]       in_tun_i,
  input  logic [4:0]       in_uinal_i,
  input  logic [4:0]       in_kin_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CorrW-1:0] cfg_data_i,
  output logic             done_o,
  output logic             valid_res_o,
  output logic [22:0]      day_number_o,
  output logic [4:0]       out_day_o,
  output logic [3:0]       out_month_o,
  output logic [13:0]      out_year_o,
  output logic [5:0]       out_baktun_o,
  output logic [4:0]       out_katun_o,
  output logic [4:0]       out_tun_o,
  output logic [4:0]       out_uinal_o,
  output logic [4:0]       out_kin_o
);

  logic             in_acc;
  logic             front_act;
  logic             greg_act;
  logic [CorrW-1:0] corr_q;
  jdn_word_t        jdn_w;
  greg_word_t       greg_w;
  lc_word_t         lc_w;

  // Give a pending config write priority over new date words
  assign busy        = cfg_valid_i;
  assign in_acc      = start && !busy;
  assign cfg_ready_o = !(front_act || greg_act || done_o);

  // Correlation register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corr_q <= CorrReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      corr_q <= cfg_data_i;
    end
  end

  gjl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_vld_i        (in_acc),
    .kind_i          (kind_i),
    .in_day_i        (in_day_i),
    .in_month_i      (in_month_i),
    .in_year_i       (in_year_i),
    .in_day_number_i (in_day_number_i),
    .in_baktun_i     (in_baktun_i),
    .in_katun_i      (in_katun_i),
    .in_tun_i        (in_tun_i),
    .in_uinal_i      (in_uinal_i),
    .in_kin_i        (in_kin_i),
    .corr_i          (corr_q),
    .jdn_o           (jdn_w),
    .active_o        (front_act)
  );

  gjl_greg u_greg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .jdn_i    (jdn_w),
    .greg_o   (greg_w),
    .active_o (greg_act)
  );

  gjl_lcount u_lcount (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .jdn_i  (jdn_w),
    .corr_i (corr_q),
    .lc_o   (lc_w)
  );

  // Output register: zero every field of a rejected date
  logic done_q;
  logic ok_q;
  logic [22:0] z_q;
  logic [4:0]  day_q;
  logic [3:0]  month_q;
  logic [13:0] year_q;
  lc_dig_t     dig_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= greg_w.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    ok_q    <= greg_w.ok;
    z_q     <= greg_w.ok ? greg_w.z : '0;
    day_q   <= greg_w.ok ? greg_w.day : '0;
    month_q <= greg_w.ok ? greg_w.month : '0;
    year_q  <= greg_w.ok ? greg_w.year : '0;
    dig_q   <= greg_w.ok ? lc_w.dig : '0;
  end

  assign done_o       = done_q;
  assign valid_res_o  = ok_q;
  assign day_number_o = z_q;
  assign out_day_o    = day_q;
  assign out_month_o  = month_q;
  assign out_year_o   = year_q;
  assign out_baktun_o = dig_q.baktun;
  assign out_katun_o  = dig_q.katun;
  assign out_tun_o    = dig_q.tun;
  assign out_uinal_o  = dig_q.uinal;
  assign out_kin_o    = dig_q.kin;

  // Both result chains must stay in lock step
  a_lane_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    greg_w.vld == lc_w.vld)
    else $error("date and long count chains out of step");

  // A rejected date leaves every field at zero; this checks the day number, month, day, baktun and kin
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !valid_res_o |-> day_number_o == '0 && out_month_o == '0 &&
      out_day_o == '0 && out_baktun_o == '0 && out_kin_o == '0)
    else $error("rejected date word carries nonzero fields");

  // A valid date comes out with a real month and day
  a_valid_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && valid_res_o |-> out_month_o >= 4'd1 && out_month_o <= 4'd12 &&
      out_day_o >= 5'd1)
    else $error("month or day out of range");

  // Quotient corrections keep the katun, tun, uinal and kin digits in range
  a_lc_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && valid_res_o |-> out_katun_o <= 5'd19 && out_tun_o <= 5'd19 &&
      out_uinal_o <= 5'd17 && out_kin_o <= 5'd19)
    else $error("long count digit out of range");

endmodule

FILE: dv/gjl_checker.sv
module gjl_checker import gjl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [1:0]       kind_i,
  input  logic [4:0]       in_day_i,
  input  logic [3:0]       in_month_i,
  input  logic [13:0]      in_year_i,
  input  logic [22:0]      in_day_number_i,
  input  logic [4:0]       in_baktun_i,
  input  logic [4:0]       in_katun_i,
  input  logic [4:0]       in_tun_i,
  input  logic [4:0]       in_uinal_i,
  input  logic [4:0]       in_kin_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CorrW-1:0] cfg_data_i,
  input  logic             done_i,
  input  logic             valid_res_i,
  input  logic [22:0]      day_number_i,
  input  logic [4:0]       out_day_i,
  input  logic [3:0]       out_month_i,
  input  logic [13:0]      out_year_i,
  input  logic [5:0]       out_baktun_i,
  input  logic [4:0]       out_katun_i,
  input  logic [4:0]       out_tun_i,
  input  logic [4:0]       out_uinal_i,
  input  logic [4:0]       out_kin_i,
  output int               errors_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 40;

  typedef struct packed {
    logic        valid;
    logic [22:0] day_number;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [5:0]  baktun;
    logic [4:0]  katun;
    logic [4:0]  tun;
    logic [4:0]  uinal;
    logic [4:0]  kin;
  } date_res_t;

  date_res_t        expected_dates[$];
  logic [CorrW-1:0] correlation;
  int               fail_count;

  // Integer division rounded toward minus infinity
  function automatic longint fdiv(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic bit leap_year(input longint y);
    return fdiv(y, 4) * 4 == y && (fdiv(y, 100) * 100 != y || fdiv(y, 400) * 400 == y);
  endfunction

  function automatic longint month_len(input longint m, input longint y);
    case (m)
      2:           return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // Check one date word and derive its day number, calendar date and long count
  function automatic date_res_t convert_date(
    input logic [1:0]       kind,
    input logic [4:0]       d_in,
    input logic [3:0]       m_in,
    input logic [13:0]      y_in,
    input logic [22:0]      dn_in,
    input logic [4:0]       bk,
    input logic [4:0]       kt,
    input logic [4:0]       tn,
    input logic [4:0]       ui,
    input logic [4:0]       kn,
    input logic [CorrW-1:0] corr
  );
    date_res_t r;
    longint    cl, z, d, m, y, jm, cent, alpha, a, b, c, dd, e, lc, q;
    bit        ok;
    r  = '0;
    ok = 1'b0;
    z  = 0;
    cl = corr;
    case (kind)
      KindGreg: begin
        d = d_in;
        m = m_in;
        y = y_in;
        if (m >= 1 && m <= 12 && d >= 1 && d <= month_len(m, y)) begin
          ok = 1'b1;
          if (m > 2) begin
            jm = m + 1;
          end else begin
            y  = y - 1;
            jm = m + 13;
          end
          z    = fdiv(1461 * y, 4) + fdiv(306001 * jm, 10000) + d + 1720995;
          cent = fdiv(y, 100);
          z    = z + 2 - cent + fdiv(cent, 4);
        end
      end
      KindJdn: begin
        z  = dn_in;
        ok = z >= cl;
      end
      KindLong: begin
        if (bk >= 1 && bk <= 19 && kt >= 1 && kt <= 19 && tn >= 1 && tn <= 19 &&
            ui >= 1 && ui <= 17 && kn >= 1 && kn <= 19) begin
          ok = 1'b1;
          z  = longint'(bk) * 144000 + longint'(kt) * 7200 + longint'(tn) * 360 +
               longint'(ui) * 20 + longint'(kn) + cl;
        end
      end
      default: ok = 1'b0;
    endcase
    if (!ok) return r;

    // Day number back to the proleptic Gregorian date
    alpha = fdiv(4 * z - 7468865, 146097);
    a     = z + 1 + alpha - fdiv(alpha, 4);
    b     = a + 1524;
    c     = fdiv(100 * b - 12210, 36525);
    dd    = fdiv(1461 * c, 4);
    e     = fdiv(10000 * (b - dd), 306001);
    d     = b - dd - fdiv(306001 * e, 10000);
    m     = (e > 13) ? e - 13 : e - 1;
    y     = (m > 2) ? c - 4716 : c - 4715;

    // Split the days since the correlation point into long-count digits
    lc = z - cl;
    q  = fdiv(lc, 144000);
    lc = lc - q * 144000;

    r.valid      = 1'b1;
    r.day_number = z[22:0];
    r.day        = d[4:0];
    r.month      = m[3:0];
    r.year       = y[13:0];
    r.baktun     = q[5:0];
    r.katun      = 5'(lc / 7200);
    lc           = lc % 7200;
    r.tun        = 5'(lc / 360);
    lc           = lc % 360;
    r.uinal      = 5'(lc / 20);
    r.kin        = 5'(lc % 20);
    return r;
  endfunction

  function automatic bit field_ok(input string name, input longint want, input longint got);
    if (want == got) return 1'b1;
    if (fail_count < MaxReports)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    return 1'b0;
  endfunction

  // Retire the oldest expectation on each result, then queue the newly taken word
  always @(posedge clk_i or negedge rst_ni) begin
    date_res_t want;
    bit        good;
    if (!rst_ni) begin
      correlation = CorrReset;
      expected_dates.delete();
      fail_count  = 0;
      errors_o   <= 0;
      pending_o  <= 0;
    end else begin
      if (done_i) begin
        if (expected_dates.size() == 0) begin
          if (fail_count < MaxReports)
            $display("%0t: result word with none expected, day_number %0d",
                     $time, day_number_i);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          good = 1'b1;
          good &= field_ok("valid_res", want.valid, valid_res_i);
          good &= field_ok("day_number", want.day_number, day_number_i);
          good &= field_ok("out_day", want.day, out_day_i);
          good &= field_ok("out_month", want.month, out_month_i);
          good &= field_ok("out_year", want.year, out_year_i);
          good &= field_ok("out_baktun", want.baktun, out_baktun_i);
          good &= field_ok("out_katun", want.katun, out_katun_i);
          good &= field_ok("out_tun", want.tun, out_tun_i);
          good &= field_ok("out_uinal", want.uinal, out_uinal_i);
          good &= field_ok("out_kin", want.kin, out_kin_i);
          if (!good) fail_count++;
        end
      end
      if (start_i && !busy_i) begin
        expected_dates.push_back(convert_date(kind_i, in_day_i, in_month_i, in_year_i,
                                              in_day_number_i, in_baktun_i, in_katun_i,
                                              in_tun_i, in_uinal_i, in_kin_i, correlation));
      end
      if (cfg_valid_i && cfg_ready_i) correlation = cfg_data_i;
      errors_o  <= fail_count;
      pending_o <= expected_dates.size();
    end
  end

endmodule

FILE: dv/tb.sv
module tb import gjl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CycleLimit = 200000;
  localparam int         DrainLimit = 1000;
  localparam int         Latency    = 12;
  localparam int         PhaseItems = 135;
  localparam logic [1:0] KindBad    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [22:0] day_number;
    logic [4:0]  baktun;
    logic [4:0]  katun;
    logic [4:0]  tun;
    logic [4:0]  uinal;
    logic [4:0]  kin;
  } date_word_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       kind;
  logic [4:0]       in_day;
  logic [3:0]       in_month;
  logic [13:0]      in_year;
  logic [22:0]      in_day_number;
  logic [4:0]       in_baktun;
  logic [4:0]       in_katun;
  logic [4:0]       in_tun;
  logic [4:0]       in_uinal;
  logic [4:0]       in_kin;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CorrW-1:0] cfg_data;
  logic             done;
  logic             valid_res;
  logic [22:0]      day_number;
  logic [4:0]       out_day;
  logic [3:0]       out_month;
  logic [13:0]      out_year;
  logic [5:0]       out_baktun;
  logic [4:0]       out_katun;
  logic [4:0]       out_tun;
  logic [4:0]       out_uinal;
  logic [4:0]       out_kin;
  int               errors;
  int               pending;
  int               cycles;
  int               burst_left;
  logic [CorrW-1:0] corr_now;

  gregorian_jdn_longcount_converter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind),
    .in_day_i        (in_day),
    .in_month_i      (in_month),
    .in_year_i       (in_year),
    .in_day_number_i (in_day_number),
    .in_baktun_i     (in_baktun),
    .in_katun_i      (in_katun),
    .in_tun_i        (in_tun),
    .in_uinal_i      (in_uinal),
    .in_kin_i        (in_kin),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .done_o          (done),
    .valid_res_o     (valid_res),
    .day_number_o    (day_number),
    .out_day_o       (out_day),
    .out_month_o     (out_month),
    .out_year_o      (out_year),
    .out_baktun_o    (out_baktun),
    .out_katun_o     (out_katun),
    .out_tun_o       (out_tun),
    .out_uinal_o     (out_uinal),
    .out_kin_o       (out_kin)
  );

  gjl_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .kind_i          (kind),
    .in_day_i        (in_day),
    .in_month_i      (in_month),
    .in_year_i       (in_year),
    .in_day_number_i (in_day_number),
    .in_baktun_i     (in_baktun),
    .in_katun_i      (in_katun),
    .in_tun_i        (in_tun),
    .in_uinal_i      (in_uinal),
    .in_kin_i        (in_kin),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .done_i          (done),
    .valid_res_i     (valid_res),
    .day_number_i    (day_number),
    .out_day_i       (out_day),
    .out_month_i     (out_month),
    .out_year_i      (out_year),
    .out_baktun_i    (out_baktun),
    .out_katun_i     (out_katun),
    .out_tun_i       (out_tun),
    .out_uinal_i     (out_uinal),
    .out_kin_i       (out_kin),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Random content in every field
  function automatic date_word_t noise_word();
    date_word_t w;
    w = date_word_t'({$urandom, $urandom, $urandom});
    return w;
  endfunction

  function automatic date_word_t greg_word(input int d, input int m, input int y);
    date_word_t w;
    w       = noise_word();
    w.kind  = KindGreg;
    w.day   = 5'(d);
    w.month = 4'(m);
    w.year  = 14'(y);
    return w;
  endfunction

  function automatic date_word_t jdn_word(input int unsigned n);
    date_word_t w;
    w            = noise_word();
    w.kind       = KindJdn;
    w.day_number = 23'(n);
    return w;
  endfunction

  function automatic date_word_t long_word(input int b, input int k, input int t,
                                           input int u, input int n);
    date_word_t w;
    w        = noise_word();
    w.kind   = KindLong;
    w.baktun = 5'(b);
    w.katun  = 5'(k);
    w.tun    = 5'(t);
    w.uinal  = 5'(u);
    w.kin    = 5'(n);
    return w;
  endfunction

  // Noise in every field under the unused kind
  function automatic date_word_t bad_word();
    date_word_t w;
    w      = noise_word();
    w.kind = KindBad;
    return w;
  endfunction

  // Mostly well-formed dates, with a share of noise and bad kinds
  function automatic date_word_t random_word(input logic [CorrW-1:0] corr);
    date_word_t  w;
    int unsigned pick;
    int unsigned shape;
    w     = noise_word();
    pick  = $urandom_range(99);
    shape = $urandom_range(9);
    if (pick < 40) begin
      w.kind = KindGreg;
      if (shape != 0) begin
        w.month = 4'($urandom_range(12, 1));
        w.day   = 5'($urandom_range(31, 1));
        if (shape > 1) w.year = 14'($urandom_range(9999, 1));
      end
    end else if (pick < 65) begin
      w.kind = KindJdn;
      if (shape > 1)
        w.day_number = 23'(corr + $urandom_range(3000000));
      else if (shape == 1)
        w.day_number = 23'(corr + $urandom_range(4) - 2);
    end else if (pick < 95) begin
      w.kind = KindLong;
      if (shape > 1) begin
        w.baktun = 5'($urandom_range(19, 1));
        w.katun  = 5'($urandom_range(19, 1));
        w.tun    = 5'($urandom_range(19, 1));
        w.uinal  = 5'($urandom_range(17, 1));
        w.kin    = 5'($urandom_range(19, 1));
      end
    end else begin
      w.kind = KindBad;
    end
    return w;
  endfunction

  // Offer one date word; gaps fall between bursts of random length
  task automatic send_date(input date_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap        = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start         <= 1'b1;
    kind          <= w.kind;
    in_day        <= w.day;
    in_month      <= w.month;
    in_year       <= w.year;
    in_day_number <= w.day_number;
    in_baktun     <= w.baktun;
    in_katun      <= w.katun;
    in_tun        <= w.tun;
    in_uinal      <= w.uinal;
    in_kin        <= w.kin;
    do @(posedge clk_i); while (busy);
    burst_left--;
  endtask

  // Hold off until every expected word is back, then let the pipe settle
  task automatic wait_drained();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (Latency) @(posedge clk_i);
  endtask

  task automatic write_correlation(input logic [CorrW-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    corr_now   = value;
    burst_left = 0;
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      send_date(random_word(corr_now));
    end
  endtask

  initial begin
    logic [CorrW-1:0] corr_list[6];
    cycles        <= 0;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    kind          <= KindGreg;
    in_day        <= '0;
    in_month      <= '0;
    in_year       <= '0;
    in_day_number <= '0;
    in_baktun     <= '0;
    in_katun      <= '0;
    in_tun        <= '0;
    in_uinal      <= '0;
    in_kin        <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    burst_left     = 0;
    corr_now       = CorrReset;
    corr_list      = '{20'd584000, 20'd585000, 20'd0, 20'hFFFFF,
                       CorrReset, CorrReset};
    corr_list[4]   = 20'($urandom_range(585000, 584000));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Calendar corners: leap rules, month lengths, bad months and days
    send_date(greg_word(1, 1, 0));
    send_date(greg_word(29, 2, 2000));
    send_date(greg_word(29, 2, 1900));
    send_date(greg_word(29, 2, 2024));
    send_date(greg_word(29, 2, 2023));
    send_date(greg_word(31, 4, 2021));
    send_date(greg_word(0, 5, 2021));
    send_date(greg_word(15, 0, 2021));
    send_date(greg_word(15, 13, 2021));
    send_date(greg_word(31, 15, 16383));
    send_date(greg_word(31, 12, 16383));
    send_date(greg_word(4, 10, 1582));
    // Day numbers around the correlation point and at full width
    send_date(jdn_word(0));
    send_date(jdn_word(CorrReset - 1));
    send_date(jdn_word(CorrReset));
    send_date(jdn_word(23'h7FFFFF));
    send_date(jdn_word(2451545));
    // Long-count digit limits, zero digits, bad kind
    send_date(long_word(13, 0, 0, 0, 0));
    send_date(long_word(1, 1, 1, 1, 1));
    send_date(long_word(19, 19, 19, 17, 19));
    send_date(long_word(20, 1, 1, 1, 1));
    send_date(long_word(1, 1, 1, 18, 1));
    send_date(long_word(31, 31, 31, 31, 31));
    send_date(bad_word());
    random_phase(PhaseItems);

    // Sweep the correlation register, extremes included
    for (int p = 0; p < 6; p++) begin
      write_correlation(corr_list[p]);
      random_phase(PhaseItems / 2);
      if (p == 1) wait_drained();
      random_phase(PhaseItems - PhaseItems / 2);
    end

    wait_drained();
    if (errors == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: gregorian_jdn_longcount_converter.f
rtl/core/gjl_pkg.sv
rtl/core/gjl_front.sv
rtl/core/gjl_greg.sv
rtl/core/gjl_lcount.sv
rtl/core/gregorian_jdn_longcount_converter.sv
dv/gjl_checker.sv
dv/tb.sv
